[rtl/tsv_address_table_sorted_lookup_macros.svh]
// assertion macros shared by the address table modules
`ifndef TSV_ADDRESS_TABLE_SORTED_LOOKUP_MACROS_SVH
`define TSV_ADDRESS_TABLE_SORTED_LOOKUP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TSVAT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TSVAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tsvat_pkg.sv]
// shared types and constants of the sorted address table
package tsvat_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ADDR_W        = 16;
    localparam int CODE_W        = 8;
    localparam int ENTRY_COUNT_W = 11;
    localparam int ACC_W         = ADDR_W + 1;

    // address accumulator limits
    localparam logic [ACC_W-1:0] ADDR_SAT = ACC_W'(65536);
    localparam logic [ACC_W-1:0] ADDR_MAX = ACC_W'(16'hFFFF);

    // text characters
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    // last (saturated) column
    localparam logic [1:0] COL_LAST = 2'd3;

    // request codes
    typedef enum logic [1:0] {
        REQ_BYTE   = 2'd0,
        REQ_EOF    = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    // result kinds
    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_LOAD   = 1'b1
    } t_kind;

    // control state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_SEARCH,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        text_byte;
        logic [ADDR_W-1:0] lookup_addr;
    } t_in_item;

    typedef struct packed {
        logic                     result_kind;
        logic                     found;
        logic [CODE_W-1:0]        type_main;
        logic [CODE_W-1:0]        type_sub;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     table_overflow;
    } t_out_item;

    // one table entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] type_main;
        logic [CODE_W-1:0] type_sub;
    } t_entry;

    // top to parser
    typedef struct packed {
        logic       byte_en;
        logic       eof_en;
        logic [7:0] text_byte;
    } t_parse_ctl;

    // parser to top: line finished and worth storing
    typedef struct packed {
        logic   keep;
        t_entry ent;
    } t_line;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   drain;
        t_entry ent;
    } t_chain_ctl;

    // search unit to top
    typedef struct packed {
        logic              done;
        logic              found;
        logic [CODE_W-1:0] type_main;
        logic [CODE_W-1:0] type_sub;
    } t_search_res;

endpackage

[rtl/tsvat_parse.sv]
// line parser: splits tab separated text into address and type code columns
module tsvat_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsvat_pkg::t_parse_ctl i_ctl,
    output tsvat_pkg::t_line      o_line
);
    import tsvat_pkg::*;

    localparam int MUL_W = ACC_W + 4;

    logic [1:0]        r_col, n_col;
    logic [ACC_W-1:0]  r_addr_acc, n_addr_acc;
    logic [CODE_W-1:0] r_main, n_main;
    logic [CODE_W-1:0] r_sub, n_sub;
    logic [2:0]        r_seen, n_seen;
    logic              r_header, n_header;

    logic              line_done;
    logic              is_digit;
    logic [7:0]        digit_diff;
    logic [3:0]        digit;
    logic [MUL_W-1:0]  addr_next;

    // code * 10 + digit, kept modulo 256
    function automatic logic [CODE_W-1:0] code_step(input logic [CODE_W-1:0] code,
                                                    input logic [3:0] dig);
        logic [CODE_W+3:0] sum;
        sum = (CODE_W+4)'({code, 3'b000}) + (CODE_W+4)'({code, 1'b0}) + (CODE_W+4)'(dig);
        return sum[CODE_W-1:0];
    endfunction

    // character classes
    assign digit_diff = i_ctl.text_byte - CH_0;
    assign digit      = digit_diff[3:0];
    assign is_digit   = (i_ctl.text_byte >= CH_0) && (i_ctl.text_byte <= CH_9);
    assign line_done  = i_ctl.eof_en || (i_ctl.byte_en && (i_ctl.text_byte == CH_LF));

    // saturating address accumulate
    always_comb begin
        addr_next = MUL_W'({r_addr_acc, 3'b000}) + MUL_W'({r_addr_acc, 1'b0})
                  + MUL_W'(digit);
    end

    // finished line check
    always_comb begin
        o_line.keep = line_done && !r_header && r_seen[0]
                    && (r_addr_acc != '0) && (r_addr_acc <= ADDR_MAX);
        o_line.ent.addr      = r_addr_acc[ADDR_W-1:0];
        o_line.ent.type_main = r_main;
        o_line.ent.type_sub  = r_sub;
    end

    // next column state
    always_comb begin
        n_col      = r_col;
        n_addr_acc = r_addr_acc;
        n_main     = r_main;
        n_sub      = r_sub;
        n_seen     = r_seen;
        n_header   = r_header;
        if (line_done) begin
            n_col      = '0;
            n_addr_acc = '0;
            n_main     = '0;
            n_sub      = '0;
            n_seen     = '0;
            n_header   = 1'b0;
        end else if (i_ctl.byte_en) begin
            if (i_ctl.text_byte == CH_TAB) begin
                if (r_col != COL_LAST) begin
                    n_col = r_col + 2'd1;
                end
            end else if ((i_ctl.text_byte != CH_CR) && (r_col != COL_LAST) && is_digit) begin
                case (r_col)
                    2'd0: begin
                        n_addr_acc = (addr_next > MUL_W'(ADDR_SAT)) ? ADDR_SAT
                                                                     : addr_next[ACC_W-1:0];
                    end
                    2'd1: begin
                        n_main = code_step(r_main, digit);
                    end
                    default: begin
                        n_sub = code_step(r_sub, digit);
                    end
                endcase
                n_seen[r_col] = 1'b1;
            end
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_addr_acc <= '0;
            r_main     <= '0;
            r_sub      <= '0;
            r_seen     <= '0;
            r_header   <= 1'b1;
        end else begin
            r_col      <= n_col;
            r_addr_acc <= n_addr_acc;
            r_main     <= n_main;
            r_sub      <= n_sub;
            r_seen     <= n_seen;
            r_header   <= n_header;
        end
    end

endmodule

[rtl/tsvat_cell.sv]
// one compare-and-shift cell of the sorting chain
module tsvat_cell (
    input  logic                  i_clk,
    input  tsvat_pkg::t_chain_ctl i_ctl,
    input  logic                  i_occ,
    input  logic                  i_occ_prev,
    input  tsvat_pkg::t_entry     i_prev_ent,
    input  logic                  i_prev_gt,
    input  tsvat_pkg::t_entry     i_next_ent,
    output tsvat_pkg::t_entry     o_ent,
    output logic                  o_gt
);
    import tsvat_pkg::*;

    t_entry r_ent, n_ent;
    logic   at_end;

    // held key sorts after the new one; equal keys stay ahead
    assign o_gt   = i_occ && (r_ent.addr > i_ctl.ent.addr);
    assign at_end = i_occ_prev && !i_occ;
    assign o_ent  = r_ent;

    // shift right on insert, left on drain
    always_comb begin
        n_ent = r_ent;
        if (i_ctl.drain) begin
            n_ent = i_next_ent;
        end else if (i_ctl.insert && (o_gt || at_end)) begin
            n_ent = i_prev_gt ? i_prev_ent : i_ctl.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

[rtl/tsvat_chain.sv]
// row of sorting cells that keeps loaded entries in stable address order
module tsvat_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsvat_pkg::t_chain_ctl         i_ctl,
    output tsvat_pkg::t_entry             o_head,
    output logic [tsvat_pkg::CNT_W-1:0]   o_count
);
    import tsvat_pkg::*;

    logic [CNT_W-1:0] r_count;
    t_entry           ent [0:TABLE_DEPTH-1];
    logic             gt  [0:TABLE_DEPTH-1];
    logic             occ [0:TABLE_DEPTH-1];

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_count = r_count;
    assign o_head  = ent[0];

    // cell row
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        t_entry prev_ent;
        t_entry next_ent;
        logic   prev_gt;
        logic   prev_occ;

        assign occ[i] = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign prev_ent = ent[i];
            assign prev_gt  = 1'b0;
            assign prev_occ = 1'b1;
        end else begin : g_mid
            assign prev_ent = ent[i-1];
            assign prev_gt  = gt[i-1];
            assign prev_occ = occ[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_last
            assign next_ent = ent[i];
        end else begin : g_inner
            assign next_ent = ent[i+1];
        end

        tsvat_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_occ      (occ[i]),
            .i_occ_prev (prev_occ),
            .i_prev_ent (prev_ent),
            .i_prev_gt  (prev_gt),
            .i_next_ent (next_ent),
            .o_ent      (ent[i]),
            .o_gt       (gt[i])
        );
    end

endmodule

[rtl/tsvat_search.sv]
`include "tsv_address_table_sorted_lookup_macros.svh"
// sealed table memory and binary search unit, one probe per cycle
module tsvat_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [tsvat_pkg::IDX_W-1:0]   i_wr_idx,
    input  tsvat_pkg::t_entry             i_wr_ent,
    input  logic                          i_start,
    input  logic [tsvat_pkg::ADDR_W-1:0]  i_key,
    input  logic [tsvat_pkg::CNT_W-1:0]   i_count,
    output tsvat_pkg::t_search_res        o_res
);
    import tsvat_pkg::*;

    t_entry            r_mem [0:TABLE_DEPTH-1];
    t_entry            r_rd;
    logic [CNT_W-1:0]  r_lo, r_hi;
    logic [IDX_W-1:0]  r_mid;
    logic [ADDR_W-1:0] r_key;
    t_entry            r_best;
    logic              r_best_ok;
    logic              r_busy;
    logic              r_done;
    logic              r_found;
    logic [CODE_W-1:0] r_main, r_sub;

    logic              go_right;
    logic [CNT_W-1:0]  n_lo, n_hi;
    t_entry            n_best;
    logic              n_best_ok;
    logic              more;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W:0]    mid_half;
    logic [CNT_W-1:0]  start_half;
    logic [IDX_W-1:0]  rd_idx;
    logic              hit;

    // one halving step against the probed entry
    always_comb begin
        go_right   = (r_rd.addr < r_key);
        n_lo       = go_right ? (CNT_W'(r_mid) + CNT_W'(1)) : r_lo;
        n_hi       = go_right ? r_hi : CNT_W'(r_mid);
        n_best     = go_right ? r_best : r_rd;
        n_best_ok  = r_best_ok || !go_right;
        more       = (n_lo < n_hi);
        mid_sum    = {1'b0, n_lo} + {1'b0, n_hi};
        mid_half   = mid_sum >> 1;
        start_half = i_count >> 1;
        rd_idx     = i_start ? start_half[IDX_W-1:0] : mid_half[IDX_W-1:0];
        hit        = n_best_ok && (n_best.addr == r_key);
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_ent;
        end
        r_rd <= r_mem[rd_idx];
    end

    // search bounds and candidate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo      <= '0;
            r_hi      <= i_count;
            r_mid     <= start_half[IDX_W-1:0];
            r_key     <= i_key;
            r_best_ok <= 1'b0;
        end else if (r_busy) begin
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_mid     <= mid_half[IDX_W-1:0];
            r_best    <= n_best;
            r_best_ok <= n_best_ok;
        end
        if (r_busy && !more) begin
            r_found <= hit;
            r_main  <= hit ? n_best.type_main : '0;
            r_sub   <= hit ? n_best.type_sub : '0;
        end
    end

    // busy and done control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !more;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && !more) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.found     = r_found;
    assign o_res.type_main = r_main;
    assign o_res.type_sub  = r_sub;

    `TSVAT_ASSERT_IMPL(a_start_idle, i_start, !r_busy, "search started while busy")
    `TSVAT_ASSERT_IMPL(a_bounds_open, r_busy, r_lo < r_hi, "search running on empty range")
    `TSVAT_ASSERT_NEXT(a_done_pulse, r_done, !r_done, "search done held for two cycles")

endmodule

[rtl/tsv_address_table_sorted_lookup.sv]
`include "tsv_address_table_sorted_lookup_macros.svh"
// top level of the sorted address table: text loader, sorting chain and lookup
//
// Text bytes are taken one per cycle while the block is idle; the newline that
// ends a data line inserts its entry into a row of TABLE_DEPTH compare-and-shift
// cells in that same cycle, so the row is always in stable address order. End
// of file flushes the last line, then copies the row into the search memory one
// entry per cycle (nothing is copied if the table was already sealed). The load
// report, like a lookup result, is registered in the reply step, and the input
// is taken again once it is in the output register. A lookup is a binary search
// over that memory with one registered probe per cycle; before sealing or on an
// empty table no probe is made and the block goes straight to its reply step.
// Results wait in an output register; text bytes keep being taken while a result
// waits there, and one lookup or end-of-file transaction is worked at a time.
// A result that cannot enter the output register holds the block in its reply
// step.
module tsv_address_table_sorted_lookup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tsvat_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tsvat_pkg::t_out_item o_out_data
);
    import tsvat_pkg::*;

    t_state           r_state, n_state;
    logic             r_sealed, n_sealed;
    logic             r_dropped, n_dropped;
    logic [CNT_W-1:0] r_idx, n_idx;
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_data, n_out_data;

    logic             in_acc;
    logic             slot_free;
    logic             room;
    logic             srch_start;
    t_parse_ctl       parse_ctl;
    t_line            line;
    t_chain_ctl       chain_ctl;
    t_entry           head;
    logic [CNT_W-1:0] count;
    t_search_res      srch_res;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign room       = (count < CNT_W'(TABLE_DEPTH));

    // parser strobes
    assign parse_ctl.byte_en   = in_acc && (i_in_data.req_type == REQ_BYTE) && !r_sealed;
    assign parse_ctl.eof_en    = in_acc && (i_in_data.req_type == REQ_EOF) && !r_sealed;
    assign parse_ctl.text_byte = i_in_data.text_byte;

    // chain control: insert finished lines, drain while sealing
    assign chain_ctl.insert = line.keep && room;
    assign chain_ctl.drain  = (r_state == ST_DRAIN) && (r_idx < count);
    assign chain_ctl.ent    = line.ent;

    assign srch_start = in_acc && (i_in_data.req_type == REQ_LOOKUP) && r_sealed
                      && (count != '0);

    tsvat_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (parse_ctl),
        .o_line  (line)
    );

    tsvat_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chain_ctl),
        .o_head  (head),
        .o_count (count)
    );

    tsvat_search u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (chain_ctl.drain),
        .i_wr_idx (r_idx[IDX_W-1:0]),
        .i_wr_ent (head),
        .i_start  (srch_start),
        .i_key    (i_in_data.lookup_addr),
        .i_count  (count),
        .o_res    (srch_res)
    );

    // next state and result staging
    always_comb begin
        n_state     = r_state;
        n_sealed    = r_sealed;
        n_dropped   = r_dropped || (line.keep && !room);
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.req_type == REQ_EOF)) begin
                    n_res             = '0;
                    n_res.result_kind = KIND_LOAD;
                    n_idx             = '0;
                    n_sealed          = 1'b1;
                    n_state           = r_sealed ? ST_REPLY : ST_DRAIN;
                end else if (in_acc && (i_in_data.req_type == REQ_LOOKUP)) begin
                    n_res             = '0;
                    n_res.result_kind = KIND_LOOKUP;
                    n_state           = srch_start ? ST_SEARCH : ST_REPLY;
                end
            end
            ST_DRAIN: begin
                if (chain_ctl.drain) begin
                    n_idx = r_idx + CNT_W'(1);
                end else begin
                    n_state = ST_REPLY;
                end
            end
            ST_SEARCH: begin
                if (srch_res.done) begin
                    n_res.found     = srch_res.found;
                    n_res.type_main = srch_res.type_main;
                    n_res.type_sub  = srch_res.type_sub;
                    n_state         = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (slot_free) begin
                    n_out_data                = r_res;
                    n_out_data.entry_count    = ENTRY_COUNT_W'(count);
                    n_out_data.table_overflow = r_dropped;
                    n_out_valid               = 1'b1;
                    n_state                   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sealed    <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sealed    <= n_sealed;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `TSVAT_ASSERT_IMPL(a_drain_sealed, r_state == ST_DRAIN, r_sealed, "drain before seal")
    `TSVAT_ASSERT_IMPL(a_done_in_search, srch_res.done, r_state == ST_SEARCH, "stray search done")
    `TSVAT_ASSERT_NEXT(a_count_held, r_state != ST_IDLE, $stable(count), "count moved while busy")
    `TSVAT_ASSERT_IMPL(a_out_from_reply, $rose(r_out_valid), $past(r_state == ST_REPLY), "result not from reply")

endmodule
